[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RHM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define RHM_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define RHM_ASSERT(label, clk, rst_n, prop, msg)
`define RHM_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

[hw/rtl/rhm_pkg.sv]
// ----------------------------------------------------------------------------
// rhm_pkg
// shared types, codes and constants of the mod 2^61-1 rolling hash
// ----------------------------------------------------------------------------
package rhm_pkg;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [60:0] HASH_MOD  = 61'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [60:0] HASH_ONE  = 61'd1;
    localparam logic [60:0] HASH_BASE = 61'd1033;
    // seven times the modulus, keeps the range difference non-negative
    localparam logic [63:0] OFFSET7P  = 64'hDFFF_FFFF_FFFF_FFF9;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  symbol;
        logic [10:0] left;
        logic [10:0] right;
    } t_req;

    typedef struct packed {
        logic [60:0] hash_value;
        logic        error;
        logic [10:0] stored_length;
    } t_rsp;

    typedef struct packed {
        logic rd;
        logic wr_pow;
        logic wr_hash;
    } t_store_cmd;

    // one folding step plus one conditional subtract, may return the modulus
    function automatic logic [60:0] rhm_fold(input logic [63:0] v);
        logic [61:0] s;
        s = {1'b0, v[60:0]} + {59'b0, v[63:61]};
        if (s > {1'b0, HASH_MOD}) begin
            s = s - {1'b0, HASH_MOD};
        end
        return s[60:0];
    endfunction

endpackage

[hw/rtl/rhm_if.sv]
// ----------------------------------------------------------------------------
// rhm_if
// valid/ready channels for requests and results of the rolling hash
// ----------------------------------------------------------------------------
interface rhm_req_if import rhm_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rhm_rsp_if import rhm_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/rolling_hash_mersenne61.sv]
// ----------------------------------------------------------------------------
// rolling_hash_mersenne61
// Polynomial rolling hash mod 2^61-1, base 1033, over a string that grows by
// one 8-bit symbol per append request; a query request returns the hash of a
// range [left, right). Each request gives exactly one result. Prefix hashes
// and base powers live in two synchronous tables of MAX_LEN+1 entries; entry 0
// reads as one from reset, so no clearing pass is needed. Requests are handled
// one at a time through the shared 31x31 multiplier: a query needs one modular
// product, an append two and a rejected request none, and a request finishes
// only once the result register is no longer held by the sink. A new request
// is taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rolling_hash_mersenne61 import rhm_pkg::*; #(
    parameter int MAX_LEN = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhm_req_if.sink    i_req,
    rhm_rsp_if.source  o_rsp
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = LEN_W;
    localparam int CW    = (LEN_W > 11) ? LEN_W : 11;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_FOLD = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_SPARE = 3'd7;

    logic [2:0]       r_state;
    logic [LEN_W-1:0] r_len;
    t_req             r_req;
    logic             r_err;
    logic [60:0]      r_val;
    logic [60:0]      r_h0;
    logic [60:0]      r_h1;
    logic [63:0]      r_acc;
    logic             r_out_valid;
    t_rsp             r_out;

    logic             req_accept;
    logic             is_append;
    logic             out_free;
    logic [CW-1:0]    left_c;
    logic [CW-1:0]    right_c;
    logic [CW-1:0]    len_c;
    logic [CW-1:0]    span_c;
    logic             full;
    logic             chk_err;

    t_store_cmd       store_cmd;
    logic [AW-1:0]    addr_h0;
    logic [AW-1:0]    addr_h1;
    logic [AW-1:0]    addr_pw;
    logic [AW-1:0]    wr_addr;
    logic [60:0]      h0_q;
    logic [60:0]      h1_q;
    logic [60:0]      pw_q;
    logic [63:0]      fold_in;
    logic [60:0]      fold_out;

    logic             mul_start;
    logic [60:0]      mul_a;
    logic [60:0]      mul_b;
    logic             mul_done;
    logic [63:0]      mul_prod;

    assign req_accept = i_req.valid && i_req.ready;
    assign is_append  = (r_req.cmd == CMD_APPEND);
    assign out_free   = !r_out_valid || o_rsp.ready;

    assign left_c  = CW'(r_req.left);
    assign right_c = CW'(r_req.right);
    assign len_c   = CW'(r_len);
    assign span_c  = right_c - left_c;
    assign full    = (r_len == LEN_W'(MAX_LEN));
    assign chk_err = is_append ? full : ((left_c > right_c) || (right_c > len_c));

    // table reads are issued once the request has passed its checks
    assign store_cmd.rd      = (r_state == S_CHK) && !chk_err;
    assign store_cmd.wr_pow  = (r_state == S_MUL1) && mul_done && is_append;
    assign store_cmd.wr_hash = (r_state == S_FOLD) && is_append;

    assign addr_h0 = is_append ? AW'(r_len) : AW'(left_c);
    assign addr_h1 = AW'(right_c);
    assign addr_pw = is_append ? AW'(r_len) : AW'(span_c);
    assign wr_addr = AW'(r_len + LEN_W'(1));

    assign fold_in  = (r_state == S_FOLD) ? r_acc : mul_prod;
    assign fold_out = rhm_fold(fold_in);

    // append: power product first, then prefix hash product
    assign mul_start = (r_state == S_LOAD) ||
                       ((r_state == S_MUL1) && mul_done && is_append);
    assign mul_a = (r_state == S_LOAD) ? (is_append ? pw_q : h0_q) : r_h0;
    assign mul_b = ((r_state == S_LOAD) && !is_append) ? pw_q : HASH_BASE;

    rhm_store #(
        .DEPTH (MAX_LEN + 1),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_cmd     (store_cmd),
        .i_addr_h0 (addr_h0),
        .i_addr_h1 (addr_h1),
        .i_addr_pw (addr_pw),
        .i_wr_addr (wr_addr),
        .i_wr_data (fold_out),
        .o_h0      (h0_q),
        .o_h1      (h1_q),
        .o_pw      (pw_q)
    );

    rhm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may load in the same cycle the old one leaves
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_accept) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= chk_err ? S_DONE : S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    if (mul_done) begin
                        r_state <= is_append ? S_MUL2 : S_FOLD;
                    end
                end
                S_MUL2: begin
                    if (mul_done) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (is_append) begin
                        r_len <= r_len + LEN_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    r_req <= i_req.payload;
                end
            end
            S_CHK: begin
                r_err <= chk_err;
                r_val <= '0;
            end
            S_LOAD: begin
                r_h0 <= h0_q;
                r_h1 <= h1_q;
            end
            S_MUL1: begin
                if (mul_done && !is_append) begin
                    r_acc <= {3'b0, r_h1} + OFFSET7P - mul_prod;
                end
            end
            S_MUL2: begin
                if (mul_done) begin
                    r_acc <= mul_prod + {56'b0, r_req.symbol};
                end
            end
            S_FOLD: begin
                r_val <= fold_out;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.hash_value    <= r_val;
                    r_out.error         <= r_err;
                    r_out.stored_length <= len_c[10:0];
                end
            end
            S_SPARE: begin
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    `RHM_ASSERT(a_len_bound, i_clk, i_rst_n, r_len <= LEN_W'(MAX_LEN), "stored length beyond table depth")
    `RHM_ASSERT(a_len_step, i_clk, i_rst_n, ($past(i_rst_n) && (r_len != $past(r_len))) |-> (r_len == $past(r_len) + LEN_W'(1)), "stored length moved by other than one")
    `RHM_ASSERT(a_wr_not_full, i_clk, i_rst_n, (store_cmd.wr_pow || store_cmd.wr_hash) |-> !full, "table written while store full")
    `RHM_ASSERT(a_err_zero, i_clk, i_rst_n, (r_out_valid && r_out.error) |-> (r_out.hash_value == '0), "error result with nonzero hash")

endmodule

[hw/rtl/rhm_store.sv]
// ----------------------------------------------------------------------------
// rhm_store
// prefix hash and power tables, registered reads, entry 0 reads one
// ----------------------------------------------------------------------------
module rhm_store import rhm_pkg::*; #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11
) (
    input  logic            i_clk,
    input  t_store_cmd      i_cmd,
    input  logic [AW-1:0]   i_addr_h0,
    input  logic [AW-1:0]   i_addr_h1,
    input  logic [AW-1:0]   i_addr_pw,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [60:0]     i_wr_data,
    output logic [60:0]     o_h0,
    output logic [60:0]     o_h1,
    output logic [60:0]     o_pw
);

    logic [60:0] r_hash_mem [DEPTH];
    logic [60:0] r_pow_mem  [DEPTH];

    logic [60:0] r_h0_q;
    logic [60:0] r_h1_q;
    logic [60:0] r_pw_q;
    logic        r_h0_zero;
    logic        r_h1_zero;
    logic        r_pw_zero;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hash) begin
            r_hash_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd) begin
            r_h0_q <= r_hash_mem[i_addr_h0];
            r_h1_q <= r_hash_mem[i_addr_h1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pow) begin
            r_pow_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd) begin
            r_pw_q <= r_pow_mem[i_addr_pw];
        end
    end

    // entry 0 is never written, reads of it always return one
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_h0_zero <= (i_addr_h0 == '0);
            r_h1_zero <= (i_addr_h1 == '0);
            r_pw_zero <= (i_addr_pw == '0);
        end
    end

    assign o_h0 = r_h0_zero ? HASH_ONE : r_h0_q;
    assign o_h1 = r_h1_zero ? HASH_ONE : r_h1_q;
    assign o_pw = r_pw_zero ? HASH_ONE : r_pw_q;

endmodule

[hw/rtl/rhm_mulmod.sv]
// ----------------------------------------------------------------------------
// rhm_mulmod
// split 31/30-bit multiply, four partial products through one 31x31 unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhm_mulmod import rhm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [60:0] i_a,
    input  logic [60:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    localparam logic [2:0] ST_LL      = 3'd0;
    localparam logic [2:0] ST_LH      = 3'd1;
    localparam logic [2:0] ST_HL      = 3'd2;
    localparam logic [2:0] ST_HH      = 3'd3;
    localparam logic [2:0] ST_ADD_HH  = 3'd4;
    localparam logic [2:0] ST_ADD_MID = 3'd5;

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_step;
    logic [60:0] r_a;
    logic [60:0] r_b;
    logic [61:0] r_pp;
    logic [61:0] r_mid;
    logic [63:0] r_acc;

    logic [30:0] m_x;
    logic [30:0] m_y;
    logic [61:0] m_prod;

    always_comb begin
        case (r_step)
            ST_LL: begin
                m_x = r_a[30:0];
                m_y = r_b[30:0];
            end
            ST_LH: begin
                m_x = r_a[30:0];
                m_y = {1'b0, r_b[60:31]};
            end
            ST_HL: begin
                m_x = {1'b0, r_a[60:31]};
                m_y = r_b[30:0];
            end
            ST_HH: begin
                m_x = {1'b0, r_a[60:31]};
                m_y = {1'b0, r_b[60:31]};
            end
            default: begin
                m_x = '0;
                m_y = '0;
            end
        endcase
    end

    assign m_prod = {31'b0, m_x} * {31'b0, m_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= ST_LL;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= ST_LL;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == ST_ADD_MID) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial product is registered, accumulation trails by one step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            case (r_step)
                ST_LL: begin
                    r_pp <= m_prod;
                end
                ST_LH: begin
                    r_acc <= {2'b0, r_pp};
                    r_pp  <= m_prod;
                end
                ST_HL: begin
                    r_mid <= r_pp;
                    r_pp  <= m_prod;
                end
                ST_HH: begin
                    r_mid <= r_mid + r_pp;
                    r_pp  <= m_prod;
                end
                ST_ADD_HH: begin
                    r_acc <= r_acc + ({2'b0, r_pp} << 1);
                end
                ST_ADD_MID: begin
                    r_acc <= r_acc + {3'b0, r_mid[29:0], 31'b0} + {32'b0, r_mid[61:30]};
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    `RHM_ASSERT(a_no_start_busy, i_clk, i_rst_n, i_start |-> !r_busy, "multiply started while busy")
    `RHM_ASSERT(a_done_follows, i_clk, i_rst_n, (r_busy && r_step == ST_ADD_MID && !i_start) |=> (r_done && !r_busy), "multiply did not finish after last step")
    `RHM_ASSERT(a_done_pulse, i_clk, i_rst_n, r_done |-> !r_busy, "done raised while still busy")
    `RHM_ASSERT_NORST(a_reset_idle, i_clk, !i_rst_n |=> (!r_busy && !r_done), "reset did not idle the multiplier")

endmodule
